@@ hw/rtl/owrs_pkg.sv @@
`timescale 1ns / 1ps

package owrs_pkg;

   // Default geometry
   localparam int ROM_BITS_DEF    = 64;
   localparam int FAMILY_BITS_DEF = 8;

   // Fixed field widths
   localparam int FAM_CODE_W = 8;
   localparam int COUNT_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FAMILY_CODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ON   = 2'd1;

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_PASS  = 2'd1,
      ACT_PAIR  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic scan_step;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_start;
      logic scan_done;
   } ctrl_status_type;

endpackage

@@ hw/rtl/owrs_ctrl.sv @@
`timescale 1ns / 1ps

module owrs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output owrs_pkg::ctrl_cmd_type    cmd,
   input  owrs_pkg::ctrl_status_type status
);
   import owrs_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_load;

   assign rsp_valid = rsp_valid_ff;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      out_load      = 1'b0;
      req_stall     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            // take an item once the result slot is free or draining
            req_stall = rsp_valid_ff && rsp_stall;
            if (req_valid && !req_stall) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.scan_start) begin
               state_in = ST_SCAN;
            end else begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Result slot is empty whenever an item is in work
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result slot busy while item in work");

   // Execute state never follows itself
   a_exec_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (state_ff != ST_EXEC))
      else $error("execute step repeated");

   // Scan end delivers a result
   a_scan_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && status.scan_done) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("scan ended without result");

endmodule

@@ hw/rtl/owrs_datapath.sv @@
`timescale 1ns / 1ps

module owrs_datapath #(
   parameter int ROM_BITS    = owrs_pkg::ROM_BITS_DEF,
   parameter int FAMILY_BITS = owrs_pkg::FAMILY_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // item capture
   input  logic [1:0]                          req_action,
   input  logic                                req_presence,
   input  logic                                req_id_bit,
   input  logic                                req_cmp_bit,
   // configuration
   input  logic                                csr_write,
   input  logic [owrs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [owrs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // control
   input  owrs_pkg::ctrl_cmd_type              cmd,
   output owrs_pkg::ctrl_status_type           status,
   // result payload
   output logic                                rsp_write_valid,
   output logic                                rsp_direction_bit,
   output logic                                rsp_pass_complete,
   output logic [ROM_BITS-1:0]                 rsp_rom_id,
   output logic [owrs_pkg::COUNT_W-1:0]        rsp_device_count,
   output logic                                rsp_search_done,
   output logic                                rsp_bus_error
);
   import owrs_pkg::*;

   localparam int IDX_W = $clog2(ROM_BITS);
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(ROM_BITS - 1);

   // Configuration
   logic [FAM_CODE_W-1:0] family_code_ff;
   logic                  filter_on_ff;

   // Captured item
   action_type act_ff;
   logic       presence_ff, id_bit_ff, cmp_bit_ff;

   // Search state
   logic [ROM_BITS-1:0] fork_ff, fork_in;
   logic [ROM_BITS-1:0] chosen_ff, chosen_in;
   logic [IDX_W-1:0]    bitpos_ff, bitpos_in;
   logic [IDX_W-1:0]    limit_ff, limit_in;
   logic                replay_ff, replay_in;
   logic [ROM_BITS-1:0] acc_ff, acc_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                finished_ff, finished_in;
   logic                pass_open_ff, pass_open_in;
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;

   // Result payload
   logic                wv_ff, wv_in;
   logic                dir_ff, dir_in;
   logic                pc_ff, pc_in;
   logic [ROM_BITS-1:0] rom_ff, rom_in;
   logic [COUNT_W-1:0]  cnt_out_ff, cnt_out_in;
   logic                done_ff, done_in;
   logic                err_ff, err_in;
   logic                out_load;

   logic [IDX_W-1:0] p;
   logic             dir;
   logic             fam_bit;

   assign rsp_write_valid   = wv_ff;
   assign rsp_direction_bit = dir_ff;
   assign rsp_pass_complete = pc_ff;
   assign rsp_rom_id        = rom_ff;
   assign rsp_device_count  = cnt_out_ff;
   assign rsp_search_done   = done_ff;
   assign rsp_bus_error     = err_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         family_code_ff <= '0;
         filter_on_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FAMILY_CODE: family_code_ff <= csr_wdata[FAM_CODE_W-1:0];
            CSR_FILTER_ON:   filter_on_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff      <= action_type'(req_action);
         presence_ff <= req_presence;
         id_bit_ff   <= req_id_bit;
         cmp_bit_ff  <= req_cmp_bit;
      end
   end

   // Family prefix bit, zero above the code width
   assign p       = bitpos_ff;
   assign fam_bit = (p < IDX_W'(FAM_CODE_W)) ? family_code_ff[p[2:0]] : 1'b0;

   // Item step and fork scan
   always_comb begin
      fork_in      = fork_ff;
      chosen_in    = chosen_ff;
      bitpos_in    = bitpos_ff;
      limit_in     = limit_ff;
      replay_in    = replay_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      finished_in  = finished_ff;
      pass_open_in = pass_open_ff;
      scan_idx_in  = scan_idx_ff;
      status       = '0;
      dir          = 1'b0;
      wv_in        = 1'b0;
      dir_in       = 1'b0;
      pc_in        = 1'b0;
      rom_in       = '0;
      err_in       = 1'b0;
      out_load     = 1'b0;

      if (cmd.exec) begin
         out_load = 1'b1;
         case (act_ff)
            ACT_START: begin
               fork_in      = '0;
               chosen_in    = '0;
               bitpos_in    = '0;
               limit_in     = '0;
               replay_in    = 1'b0;
               acc_in       = '0;
               count_in     = '0;
               finished_in  = 1'b0;
               pass_open_in = 1'b0;
            end
            ACT_PASS: begin
               if (!finished_ff) begin
                  if (presence_ff) begin
                     pass_open_in = 1'b1;
                     bitpos_in    = '0;
                     acc_in       = '0;
                  end else begin
                     pass_open_in = 1'b0;
                     finished_in  = 1'b1;
                  end
               end
            end
            ACT_PAIR: begin
               if (pass_open_ff && !finished_ff) begin
                  if (replay_ff && p <= limit_ff) begin
                     dir = chosen_ff[p];
                  end else if (filter_on_ff && int'(p) < FAMILY_BITS) begin
                     dir          = fam_bit;
                     chosen_in[p] = dir;
                  end else if (id_bit_ff && cmp_bit_ff) begin
                     // bus error ends pass and search
                     pass_open_in = 1'b0;
                     finished_in  = 1'b1;
                     replay_in    = 1'b0;
                     pc_in        = 1'b1;
                     err_in       = 1'b1;
                  end else if (id_bit_ff != cmp_bit_ff) begin
                     dir          = id_bit_ff;
                     chosen_in[p] = dir;
                  end else if (!fork_ff[p]) begin
                     fork_in[p]   = 1'b1;
                     dir          = 1'b1;
                     chosen_in[p] = 1'b1;
                  end else begin
                     dir          = 1'b0;
                     chosen_in[p] = 1'b0;
                  end

                  if (!err_in) begin
                     acc_in[p] = acc_ff[p] | dir;
                     wv_in     = 1'b1;
                     dir_in    = dir;
                     if (p == LAST_POS) begin
                        // pass finished: count device, then scan back
                        pass_open_in = 1'b0;
                        bitpos_in    = '0;
                        if (count_ff != '1) begin
                           count_in = count_ff + 1'b1;
                        end
                        pc_in             = 1'b1;
                        rom_in            = acc_in;
                        scan_idx_in       = LAST_POS;
                        status.scan_start = 1'b1;
                     end else begin
                        bitpos_in = p + 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      // Backward scan, one position a cycle
      if (cmd.scan_step) begin
         if (fork_ff[scan_idx_ff] && chosen_ff[scan_idx_ff]) begin
            chosen_in[scan_idx_ff] = 1'b0;
            limit_in               = scan_idx_ff;
            replay_in              = 1'b1;
            status.scan_done       = 1'b1;
         end else begin
            if (fork_ff[scan_idx_ff]) begin
               fork_in[scan_idx_ff] = 1'b0;
            end
            if (scan_idx_ff == '0) begin
               replay_in        = 1'b0;
               finished_in      = 1'b1;
               status.scan_done = 1'b1;
            end else begin
               scan_idx_in = scan_idx_ff - 1'b1;
            end
         end
      end
   end

   // Search state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fork_ff      <= '0;
         chosen_ff    <= '0;
         bitpos_ff    <= '0;
         limit_ff     <= '0;
         replay_ff    <= 1'b0;
         acc_ff       <= '0;
         count_ff     <= '0;
         finished_ff  <= 1'b1;
         pass_open_ff <= 1'b0;
         scan_idx_ff  <= '0;
      end else begin
         fork_ff      <= fork_in;
         chosen_ff    <= chosen_in;
         bitpos_ff    <= bitpos_in;
         limit_ff     <= limit_in;
         replay_ff    <= replay_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         finished_ff  <= finished_in;
         pass_open_ff <= pass_open_in;
         scan_idx_ff  <= scan_idx_in;
      end
   end

   // Result payload: loaded on execute, done flag refreshed at scan end
   assign cnt_out_in = count_in;
   assign done_in    = finished_in;

   always_ff @(posedge clock) begin
      if (out_load) begin
         wv_ff      <= wv_in;
         dir_ff     <= dir_in;
         pc_ff      <= pc_in;
         rom_ff     <= rom_in;
         cnt_out_ff <= cnt_out_in;
         err_ff     <= err_in;
      end
      if (out_load || status.scan_done) begin
         done_ff <= done_in;
      end
   end

endmodule

@@ hw/rtl/one_wire_rom_search_engine_top.sv @@
`timescale 1ns / 1ps
// Start, pass start and inner bit pairs: the result is registered out of the execute state.
// Last bit of a pass: the result also waits for the backward fork scan, which walks
// one id position a cycle from the top bit down.
// A new item is taken only in idle, once the last one is done and its result slot is free or draining.
// Reset (synchronous, active high): search finished, no pass open, fork record clear.
module one_wire_rom_search_engine_top #(
   parameter int ROM_BITS    = owrs_pkg::ROM_BITS_DEF,
   parameter int FAMILY_BITS = owrs_pkg::FAMILY_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_action,
   input  logic                             req_presence,
   input  logic                             req_id_bit,
   input  logic                             req_cmp_bit,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_write_valid,
   output logic                             rsp_direction_bit,
   output logic                             rsp_pass_complete,
   output logic [ROM_BITS-1:0]              rsp_rom_id,
   output logic [owrs_pkg::COUNT_W-1:0]     rsp_device_count,
   output logic                             rsp_search_done,
   output logic                             rsp_bus_error,
   // configuration
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [owrs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [owrs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import owrs_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Registers take a write in any cycle
   assign csr_ready = 1'b1;

   owrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   owrs_datapath #(
      .ROM_BITS    (ROM_BITS),
      .FAMILY_BITS (FAMILY_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_action),
      .req_presence      (req_presence),
      .req_id_bit        (req_id_bit),
      .req_cmp_bit       (req_cmp_bit),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .status            (status),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_direction_bit (rsp_direction_bit),
      .rsp_pass_complete (rsp_pass_complete),
      .rsp_rom_id        (rsp_rom_id),
      .rsp_device_count  (rsp_device_count),
      .rsp_search_done   (rsp_search_done),
      .rsp_bus_error     (rsp_bus_error)
   );

endmodule

@@ test/one_wire_rom_search_engine_top_tb.sv @@
`timescale 1ns / 1ps

module one_wire_rom_search_engine_top_tb;

   import owrs_pkg::*;

   localparam int ROM_BITS    = ROM_BITS_DEF;
   localparam int FAMILY_BITS = FAMILY_BITS_DEF;

   // One result transaction, field for field
   typedef struct packed {
      logic                write_valid;
      logic                direction_bit;
      logic                pass_complete;
      logic [ROM_BITS-1:0] rom_id;
      logic [COUNT_W-1:0]  device_count;
      logic                search_done;
      logic                bus_error;
   } search_result_type;

   // Directed stimulus row; typed rows carry an idle or bus-error result
   typedef struct packed {
      action_type         act;
      logic               pres;
      logic               id_bit;
      logic               cmp_bit;
      logic               typed;
      logic [COUNT_W-1:0] count;
      logic               done;
      logic               err;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_action = ACT_NONE;
   logic                  req_presence = 1'b0;
   logic                  req_id_bit = 1'b0;
   logic                  req_cmp_bit = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_write_valid;
   logic                  rsp_direction_bit;
   logic                  rsp_pass_complete;
   logic [ROM_BITS-1:0]   rsp_rom_id;
   logic [COUNT_W-1:0]    rsp_device_count;
   logic                  rsp_search_done;
   logic                  rsp_bus_error;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FAMILY_CODE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Search state mirror
   bit [ROM_BITS-1:0]  fork_mark;
   bit [ROM_BITS-1:0]  path_dir;
   int unsigned        cur_bit;
   int unsigned        replay_top;
   bit                 replaying;
   bit [ROM_BITS-1:0]  id_bits;
   int unsigned        devices_found;
   bit                 search_over;
   bit                 pass_running;
   bit [FAM_CODE_W-1:0] family_prefix;
   bit                 prefix_on;

   // Simulated devices on the bus
   bit [ROM_BITS-1:0]  device_ids[$];

   search_result_type  pending_results[$];
   plan_row_type       plan [18];

   int send_idle_pct = 24;
   int rsp_idle_pct  = 83;
   int items_sent;
   int results_checked;
   int mismatches;
   int roms_found;
   int bus_errors;
   int peak_count;

   one_wire_rom_search_engine_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_presence      (req_presence),
      .req_id_bit        (req_id_bit),
      .req_cmp_bit       (req_cmp_bit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_direction_bit (rsp_direction_bit),
      .rsp_pass_complete (rsp_pass_complete),
      .rsp_rom_id        (rsp_rom_id),
      .rsp_device_count  (rsp_device_count),
      .rsp_search_done   (rsp_search_done),
      .rsp_bus_error     (rsp_bus_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   function automatic void clear_search_state();
      fork_mark     = '0;
      path_dir      = '0;
      cur_bit       = 0;
      replay_top    = 0;
      replaying     = 1'b0;
      id_bits       = '0;
      devices_found = 0;
   endfunction

   // Walk back from the top bit to the last fork still taken as 1
   function automatic void scan_open_forks();
      bit found;
      found = 1'b0;
      for (int i = ROM_BITS - 1; i >= 0 && !found; i--) begin
         if (fork_mark[i]) begin
            if (!path_dir[i]) begin
               fork_mark[i] = 1'b0;
            end else begin
               path_dir[i] = 1'b0;
               replay_top  = i;
               replaying   = 1'b1;
               found       = 1'b1;
            end
         end
      end
      if (!found) begin
         replaying   = 1'b0;
         search_over = 1'b1;
      end
   endfunction

   function automatic search_result_type search_step(input action_type act, input bit pres,
                                                     input bit idb, input bit cmpb);
      search_result_type r;
      int unsigned       p;
      bit                dir;
      bit                aborted;
      r       = '0;
      dir     = 1'b0;
      aborted = 1'b0;
      case (act)
         ACT_START: begin
            clear_search_state();
            search_over  = 1'b0;
            pass_running = 1'b0;
         end
         ACT_PASS: begin
            if (!search_over) begin
               if (pres) begin
                  pass_running = 1'b1;
                  cur_bit      = 0;
                  id_bits      = '0;
               end else begin
                  pass_running = 1'b0;
                  search_over  = 1'b1;
               end
            end
         end
         ACT_PAIR: begin
            if (pass_running && !search_over) begin
               p = cur_bit % ROM_BITS;
               if (replaying && p <= replay_top) begin
                  dir = path_dir[p];
               end else if (prefix_on && p < FAMILY_BITS) begin
                  dir = (p < FAM_CODE_W) ? family_prefix[p] : 1'b0;
                  path_dir[p] = dir;
               end else if (idb && cmpb) begin
                  // nobody answered: the search is over
                  pass_running    = 1'b0;
                  search_over     = 1'b1;
                  replaying       = 1'b0;
                  r.pass_complete = 1'b1;
                  r.bus_error     = 1'b1;
                  aborted         = 1'b1;
               end else if (idb != cmpb) begin
                  dir = idb;
                  path_dir[p] = dir;
               end else if (!fork_mark[p]) begin
                  fork_mark[p] = 1'b1;
                  dir = 1'b1;
                  path_dir[p] = 1'b1;
               end else begin
                  dir = 1'b0;
                  path_dir[p] = 1'b0;
               end
               if (!aborted) begin
                  id_bits[p]      = dir;
                  cur_bit         = p + 1;
                  r.write_valid   = 1'b1;
                  r.direction_bit = dir;
                  if (cur_bit >= ROM_BITS) begin
                     r.rom_id        = id_bits;
                     r.pass_complete = 1'b1;
                     pass_running    = 1'b0;
                     cur_bit         = 0;
                     if (devices_found < 255) devices_found++;
                     scan_open_forks();
                  end
               end
            end
         end
         default: ;
      endcase
      r.device_count = COUNT_W'(devices_found);
      r.search_done  = search_over;
      return r;
   endfunction

   // Wired-AND answer of the devices still matching the path written so far
   function automatic void bus_read(input int p, input bit [ROM_BITS-1:0] path,
                                    output bit idb, output bit cmpb);
      bit [ROM_BITS-1:0] mask;
      mask = (64'd1 << p) - 64'd1;
      idb  = 1'b1;
      cmpb = 1'b1;
      foreach (device_ids[d]) begin
         if (((device_ids[d] ^ path) & mask) == '0) begin
            idb  = idb & device_ids[d][p];
            cmpb = cmpb & ~device_ids[d][p];
         end
      end
   endfunction

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------

   task automatic send_item(input action_type act, input bit pres, input bit idb,
                            input bit cmpb, input bit typed,
                            input search_result_type typed_want,
                            output search_result_type res);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_presence <= pres;
      req_id_bit   <= idb;
      req_cmp_bit  <= cmpb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      res = search_step(act, pres, idb, cmpb);
      pending_results.push_back(typed ? typed_want : res);
      items_sent++;
   endtask

   // Drop valid and wait for every outstanding result
   task automatic hold_off();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_FAMILY_CODE) begin
         family_prefix = data;
      end else if (idx == CSR_FILTER_ON) begin
         prefix_on = data[0];
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic build_devices(input int n);
      bit [ROM_BITS-1:0] id;
      device_ids.delete();
      for (int d = 0; d < n; d++) begin
         case ($urandom_range(0, 7))
            0: id = '0;
            1: id = '1;
            2, 3: begin
               // near neighbor of the previous one: forks deep in the tree
               if (d > 0) id = device_ids[d-1] ^ (64'd1 << $urandom_range(0, ROM_BITS - 1));
               else id = {$urandom, $urandom};
            end
            default: id = {$urandom, $urandom};
         endcase
         if (prefix_on && $urandom_range(0, 3) != 0) id[FAM_CODE_W-1:0] = family_prefix;
         device_ids.push_back(id);
      end
   endtask

   // One pass over the bus; noisy passes may be cut short or get garbage pairs
   task automatic run_bus_pass(input bit noisy);
      search_result_type res;
      bit [ROM_BITS-1:0] path;
      bit                pres;
      bit                idb;
      bit                cmpb;
      int                r;
      pres = (device_ids.size() != 0) && !(noisy && $urandom_range(0, 49) == 0);
      send_item(ACT_PASS, pres, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'b0, '0, res);
      path = '0;
      for (int p = 0; p < ROM_BITS; p++) begin
         if (search_over || !pass_running) break;
         r = noisy ? $urandom_range(0, 199) : 200;
         if (r == 0) begin
            send_item(ACT_START, 1'b0, 1'b0, 1'b0, 1'b0, '0, res);
            break;
         end
         if (r == 1) break;   // next pass start lands mid-pass
         bus_read(p, path, idb, cmpb);
         if (r < 6) begin
            idb  = 1'($urandom_range(0, 1));
            cmpb = 1'($urandom_range(0, 1));
         end
         send_item(ACT_PAIR, 1'($urandom_range(0, 1)), idb, cmpb, 1'b0, '0, res);
         path[p] = res.direction_bit;
      end
   endtask

   task automatic run_search(input bit noisy);
      search_result_type res;
      int                passes;
      send_item(ACT_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b0, '0, res);
      passes = 0;
      while (!search_over && passes < 4 * device_ids.size() + 8) begin
         run_bus_pass(noisy);
         passes++;
      end
   endtask

   // Mostly full searches, the rest loose transactions of any kind
   task automatic random_phase(input int target);
      search_result_type res;
      int                first;
      first = items_sent;
      while (items_sent - first < target) begin
         if ($urandom_range(0, 9) < 8) begin
            build_devices(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3));
            run_search(1'b1);
         end else begin
            repeat ($urandom_range(1, 8))
               send_item(action_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0, res);
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Result channel: stall and check
   // ---------------------------------------------------------------

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      search_result_type got;
      search_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_write_valid, rsp_direction_bit, rsp_pass_complete, rsp_rom_id,
                 rsp_device_count, rsp_search_done, rsp_bus_error};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result transaction, rom_id %h", $realtime, rsp_rom_id);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (want.pass_complete && !want.bus_error) roms_found++;
            if (want.bus_error) bus_errors++;
            if (want.device_count > peak_count) peak_count = want.device_count;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: mismatch wv %b/%b dir %b/%b done_pass %b/%b rom %h/%h ",
                            "count %0d/%0d search_done %b/%b err %b/%b (expected/actual)"},
                           $realtime, want.write_valid, got.write_valid,
                           want.direction_bit, got.direction_bit,
                           want.pass_complete, got.pass_complete, want.rom_id, got.rom_id,
                           want.device_count, got.device_count,
                           want.search_done, got.search_done, want.bus_error, got.bus_error);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------

   initial begin
      search_result_type res;
      search_result_type want;
      clear_search_state();
      search_over   = 1'b1;
      pass_running  = 1'b0;
      family_prefix = '0;
      prefix_on     = 1'b0;

      //          act        pres  id    cmp   typed count done  err
      plan = '{'{ACT_PAIR,  1'b1, 1'b0, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0},  // pair, no search
               '{ACT_PASS,  1'b1, 1'b1, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0},  // pass while finished
               '{ACT_NONE,  1'b1, 1'b1, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0},
               '{ACT_START, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0},
               '{ACT_PAIR,  1'b0, 1'b1, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0},  // pair before pass start
               '{ACT_PASS,  1'b0, 1'b0, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0},  // no presence
               '{ACT_START, 1'b1, 1'b1, 1'b1, 1'b1, 8'd0, 1'b0, 1'b0},
               '{ACT_PASS,  1'b1, 1'b0, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0},
               '{ACT_PAIR,  1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},
               '{ACT_PAIR,  1'b1, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0},
               '{ACT_PAIR,  1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},  // fork
               '{ACT_PASS,  1'b1, 1'b1, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0},  // restart mid-pass
               '{ACT_PAIR,  1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0},  // fork at bit 0
               '{ACT_NONE,  1'b0, 1'b0, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0},
               '{ACT_PAIR,  1'b1, 1'b1, 1'b1, 1'b1, 8'd0, 1'b1, 1'b1},  // bus error
               '{ACT_PAIR,  1'b0, 1'b0, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0},
               '{ACT_PASS,  1'b1, 1'b0, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0},
               '{ACT_START, 1'b0, 1'b1, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0}};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows at reset configuration
      for (int k = 0; k < $size(plan); k++) begin
         want = '0;
         want.pass_complete = plan[k].err;
         want.bus_error     = plan[k].err;
         want.device_count  = plan[k].count;
         want.search_done   = plan[k].done;
         send_item(plan[k].act, plan[k].pres, plan[k].id_bit, plan[k].cmp_bit,
                   plan[k].typed, want, res);
      end

      // All-zero and all-one ids: fork at bit 0, extreme rom_id values
      device_ids.delete();
      device_ids.push_back('0);
      device_ids.push_back('1);
      run_search(1'b0);
      device_ids.delete();
      run_search(1'b0);

      // Phase A: sender mostly busy, receiver mostly stalled, prefix of zeros
      hold_off();
      csr_write(CSR_FAMILY_CODE, 8'h00);
      csr_write(CSR_FILTER_ON, {7'($urandom_range(0, 127)), 1'b1});
      random_phase(170);

      // Phase B: roles swapped, prefix of ones
      hold_off();
      send_idle_pct = 83;
      rsp_idle_pct  = 24;
      csr_write(CSR_FAMILY_CODE, 8'hFF);
      csr_write(CSR_FILTER_ON, 8'h01);
      random_phase(170);

      // Phase C: no idling, filter off
      hold_off();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      csr_write(CSR_FAMILY_CODE, 8'($urandom_range(1, 254)));
      csr_write(CSR_FILTER_ON, {7'($urandom_range(0, 127)), 1'b0});
      random_phase(170);

      hold_off();
      repeat (ROM_BITS + 16) @(negedge clock);
      $display("Run covered %0d request transactions and %0d checked results (%0d mismatches).",
               items_sent, results_checked, mismatches);
      $display("Searches read out %0d ROM ids, hit %0d bus errors, device count peaked at %0d.",
               roms_found, bus_errors, peak_count);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Watchdog expired with %0d results outstanding", pending_results.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
